// ===== hw/rtl/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants for the lidar frame decoder
// Frame phase encoding, status codes, field widths and the decoded frame view.
// ----------------------------------------------------------------------------
`default_nettype none

package lfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned DistW   = 20;
  localparam int unsigned WordW   = 16;
  localparam int unsigned TempW   = 17;
  localparam int unsigned StatW   = 2;
  localparam int unsigned PayLen  = 6;

  localparam logic [ByteW-1:0] HEADER_BYTE = 8'h59;
  localparam logic [DistW-1:0] LIMIT_RESET = 20'd10000;
  localparam logic signed [TempW-1:0] TEMP_OFFSET = 17'sd2048;

  // Frame phase: hunt, second header, six payload bytes, checksum.
  typedef enum logic [3:0] {
    PH_HUNT = 4'd0,
    PH_HDR2 = 4'd1,
    PH_PL0  = 4'd2,
    PH_PL1  = 4'd3,
    PH_PL2  = 4'd4,
    PH_PL3  = 4'd5,
    PH_PL4  = 4'd6,
    PH_PL5  = 4'd7,
    PH_CSUM = 4'd8
  } phase_t;

  typedef enum logic [StatW-1:0] {
    ST_VALID    = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_RANGE    = 2'd2
  } frame_status_t;

  // Decoded view of the byte under work, from the parser to the top level.
  typedef struct packed {
    logic              last;      // byte under work is the checksum byte
    logic              sum_ok;    // running sum matches the checksum byte
    logic [WordW-1:0]  dist_cm;
    logic [WordW-1:0]  strength;
    logic [WordW-1:0]  temp_raw;
  } frame_info_t;

endpackage : lfd_pkg

`default_nettype wire

// ===== hw/rtl/lfd_channels.sv =====
// ----------------------------------------------------------------------------
// lfd_channels: valid/ready channel interfaces of the lidar frame decoder
// One interface for received bytes, one for decoded frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfd_in_if
  import lfd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface : lfd_in_if

interface lfd_out_if
  import lfd_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [DistW-1:0]        distance_mm;
  logic [WordW-1:0]        signal_strength;
  logic signed [TempW-1:0] temp_eighths;
  logic [StatW-1:0]        frame_status;

  modport source (output valid, output distance_mm, output signal_strength,
                  output temp_eighths, output frame_status, input ready);
  modport sink   (input valid, input distance_mm, input signal_strength,
                  input temp_eighths, input frame_status, output ready);
endinterface : lfd_out_if

`default_nettype wire

// ===== hw/rtl/lfd_byte_parser.sv =====
// ----------------------------------------------------------------------------
// lfd_byte_parser: frame phase tracker, payload shift line and running sum
// Consumes one byte per strobe and reports the decoded frame on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_byte_parser
  import lfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_vld,
  input  wire logic [ByteW-1:0] byte_in,
  output frame_info_t           frm
);

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] store_r [PayLen];
  logic             is_payload;

  // Next phase and running sum.
  always_comb begin
    phase_nxt  = phase_r;
    sum_nxt    = sum_r;
    is_payload = 1'b0;
    unique case (phase_r)
      PH_HUNT: begin
        if (byte_in == HEADER_BYTE) begin
          phase_nxt = PH_HDR2;
          sum_nxt   = HEADER_BYTE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_HDR2: begin
        if (byte_in == HEADER_BYTE) begin
          phase_nxt = PH_PL0;
          sum_nxt   = sum_r + HEADER_BYTE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_PL0, PH_PL1, PH_PL2, PH_PL3, PH_PL4, PH_PL5: begin
        phase_nxt  = phase_t'(phase_r + 4'd1);
        sum_nxt    = sum_r + byte_in;
        is_payload = 1'b1;
      end
      PH_CSUM: begin
        phase_nxt = PH_HUNT;
        sum_nxt   = '0;
      end
      default: begin
        // unused codes behave as hunting
        if (byte_in == HEADER_BYTE) begin
          phase_nxt = PH_HDR2;
          sum_nxt   = HEADER_BYTE;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  // Decoded outputs; after six shifts store_r[0] holds payload byte 0.
  always_comb begin
    frm.last     = (phase_r == PH_CSUM);
    frm.sum_ok   = (sum_r == byte_in);
    frm.dist_cm  = {store_r[1], store_r[0]};
    frm.strength = {store_r[3], store_r[2]};
    frm.temp_raw = {store_r[5], store_r[4]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= '0;
    end else if (byte_vld) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_vld && is_payload) begin
      for (int i = 0; i < PayLen - 1; i++) begin
        store_r[i] <= store_r[i+1];
      end
      store_r[PayLen-1] <= byte_in;
    end
  end

  a_sum_cleared_after_frame: assert property (
    @(posedge clk) disable iff (!rst_n)
    (byte_vld && frm.last) |=> (sum_r == '0) && (phase_r == PH_HUNT))
    else $error("running sum or phase not cleared after checksum byte");

  a_phase_in_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    phase_r <= PH_CSUM)
    else $error("frame phase left the legal range");

  a_hdr2_sum_is_header: assert property (
    @(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR2) |-> (sum_r == HEADER_BYTE))
    else $error("running sum wrong while awaiting second header");

endmodule : lfd_byte_parser

`default_nettype wire

// ===== hw/rtl/lidar_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_frame_decoder_unit: nine-byte lidar serial frame decoder
// Hunts 0x59 0x59, collects six payload bytes, checks the sum and emits
// distance, strength, temperature and status once per frame.
// ----------------------------------------------------------------------------
//  channel | dir | transfer payload                                | handshake
//  --------+-----+--------------------------------------------------+-----------
//  in_ch   | in  | rx_byte[7:0]                                     | valid/ready
//  out_ch  | out | distance_mm, signal_strength, temp_eighths,      | valid/ready
//          |     | frame_status                                     |
//  cfg_*   | in  | cfg_wr_data[19:0] = distance limit in mm         | write enable
//
//  Flow: one byte per cycle sustained while no checksum byte stalls; each byte
//  is held in the input register, and a frame's result in the result register.
//  Reset: synchronous active-low rst_n returns to hunting the first header,
//  clears the running sum and loads the distance limit with 10000.
//  Stalls: only a checksum byte waits, and only while the result register
//  still holds an untaken result; other bytes keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_frame_decoder_unit
  import lfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [DistW-1:0] cfg_wr_data,
  lfd_in_if.sink                in_ch,
  lfd_out_if.source             out_ch
);

  logic [DistW-1:0] limit_r;

  // Input register
  logic             in_vld_r;
  logic [ByteW-1:0] in_byte_r;
  logic             in_xfer;
  logic             proc;

  // Result register
  logic                    out_vld_r;
  logic [DistW-1:0]        dist_r;
  logic [WordW-1:0]        strength_r;
  logic signed [TempW-1:0] temp_r;
  frame_status_t           status_r;
  logic                    out_load;

  frame_info_t             frm;
  logic [DistW-1:0]        dist_mm;
  frame_status_t           status_nxt;

  lfd_byte_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (proc),
    .byte_in  (in_byte_r),
    .frm      (frm)
  );

  // Advance the held byte unless it completes a frame and the result
  // register cannot take the new result this cycle.
  assign proc     = in_vld_r && (!frm.last || !out_vld_r || out_ch.ready);
  assign out_load = proc && frm.last;

  assign in_ch.ready = !in_vld_r || proc;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // cm to mm: x*10 = x*8 + x*2
  assign dist_mm = {1'b0, frm.dist_cm, 3'b000} + {3'b000, frm.dist_cm, 1'b0};

  // Checksum mismatch outranks the range check.
  always_comb begin
    priority if (!frm.sum_ok) begin
      status_nxt = ST_CSUM_ERR;
    end else if (dist_mm >= limit_r) begin
      status_nxt = ST_RANGE;
    end else begin
      status_nxt = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Hold the byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Result valid: set on a finished frame, drop once the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dist_r     <= dist_mm;
      strength_r <= frm.strength;
      temp_r     <= $signed({1'b0, frm.temp_raw}) - TEMP_OFFSET;
      status_r   <= status_nxt;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.distance_mm     = dist_r;
  assign out_ch.signal_strength = strength_r;
  assign out_ch.temp_eighths    = temp_r;
  assign out_ch.frame_status    = status_r;

  a_in_captured: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_vld_r)
    else $error("accepted byte not held in input register");

  a_stall_only_on_full_result: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_vld_r && !proc) |-> (frm.last && out_vld_r && !out_ch.ready))
    else $error("input stalled without a blocked result");

  a_csum_flag_follows_sum: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_load |=> out_vld_r && ((status_r == ST_CSUM_ERR) == $past(!frm.sum_ok)))
    else $error("checksum status does not match running sum compare");

endmodule : lidar_frame_decoder_unit

`default_nettype wire

// ===== tb/sv/lidar_frame_decoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// lidar_frame_decoder_unit_test: self-checking bench for the frame decoder
// Streams serial bytes (good frames, bad sums, broken headers, noise) into the
// decoder under random idling and back-pressure. It predicts every decoded
// frame in step with the input transfers and checks each result field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module lidar_frame_decoder_unit_test;
  import lfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;  // generous ceiling on the whole run
  localparam int CFG_SETTLE  = 4;       // covers a byte still in the input register
  localparam int TAIL_CYCLES = 8;
  localparam int LONG_HOLD   = 200;     // receiver hold-off that backs up the input

  // One decoded frame as the result channel carries it.
  typedef struct {
    logic [DistW-1:0]        dist_mm;
    logic [WordW-1:0]        strength;
    logic signed [TempW-1:0] temp;
    frame_status_t           status;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [DistW-1:0] cfg_wr_data = '0;

  lfd_in_if  in_ch ();
  lfd_out_if out_ch ();

  lidar_frame_decoder_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Clock: 12 time units per period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder state as the bench tracks it.
  phase_t           parse_phase = PH_HUNT;
  logic [ByteW-1:0] payload_bytes [PayLen];
  logic [ByteW-1:0] frame_sum = '0;
  logic [DistW-1:0] limit_mm = LIMIT_RESET;

  frame_result_t frames_due [$];    // predicted frames not yet seen on out_ch
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // Knobs the tests turn.
  bit idle_on  = 1'b1;  // sender inserts random gaps
  bit stall_on = 1'b1;  // receiver drops ready at random
  bit hold_req = 1'b0;  // receiver does one long hold-off (LONG_HOLD)

  // Advance the parser by one accepted byte; queue a frame on the checksum byte.
  task automatic decode_byte(input logic [ByteW-1:0] b);
    frame_result_t fr;
    case (parse_phase)
      PH_HDR2: begin
        // A broken second header is consumed; hunting restarts after it.
        if (b == HEADER_BYTE) begin
          frame_sum   = frame_sum + b;
          parse_phase = PH_PL0;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
      PH_PL0, PH_PL1, PH_PL2, PH_PL3, PH_PL4, PH_PL5: begin
        payload_bytes[parse_phase - PH_PL0] = b;
        frame_sum   = frame_sum + b;
        parse_phase = phase_t'(parse_phase + 4'd1);
      end
      PH_CSUM: begin
        fr.dist_mm  = DistW'({payload_bytes[1], payload_bytes[0]} * 10);
        fr.strength = {payload_bytes[3], payload_bytes[2]};
        fr.temp     = $signed({1'b0, payload_bytes[5], payload_bytes[4]}) - TEMP_OFFSET;
        // A bad sum wins over the range check; fields still carry the payload.
        if (frame_sum != b)
          fr.status = ST_CSUM_ERR;
        else if (fr.dist_mm >= limit_mm)
          fr.status = ST_RANGE;
        else
          fr.status = ST_VALID;
        frames_due.push_back(fr);
        parse_phase = PH_HUNT;
        frame_sum   = '0;
      end
      default: begin
        // Hunting: only a header byte starts a frame.
        if (b == HEADER_BYTE) begin
          frame_sum   = HEADER_BYTE;
          parse_phase = PH_HDR2;
        end else begin
          parse_phase = PH_HUNT;
        end
      end
    endcase
  endtask

  // Check the result transfer first, then track the input transfer of the same
  // edge: a checksum byte passes the input and result registers before out_ch.
  always @(posedge clk) begin : transfer_watch
    frame_result_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (frames_due.size() == 0) begin
        $error("result transfer with no frame pending");
        mismatch_count++;
      end else begin
        due = frames_due.pop_front();
        if (out_ch.distance_mm !== due.dist_mm) begin
          $error("distance_mm: expected %0d, got %0d", due.dist_mm, out_ch.distance_mm);
          mismatch_count++;
        end
        if (out_ch.signal_strength !== due.strength) begin
          $error("signal_strength: expected %0d, got %0d",
                 due.strength, out_ch.signal_strength);
          mismatch_count++;
        end
        if (out_ch.temp_eighths !== due.temp) begin
          $error("temp_eighths: expected %0d, got %0d", due.temp, out_ch.temp_eighths);
          mismatch_count++;
        end
        if (out_ch.frame_status !== due.status) begin
          $error("frame_status: expected %0d, got %0d", due.status, out_ch.frame_status);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      decode_byte(in_ch.rx_byte);
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lidar_frame_decoder_unit_test: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0)
      return $urandom_range(10, 40);
    else if (r < 8)
      return 0;
    else
      return $urandom_range(1, 3);
  endfunction

  // Result receiver: random stalls, plus the long hold-off on request.
  initial begin : result_sink
    int held;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++)
          @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte and hold it until transferred. Valid stays high on return so
  // that back-to-back bytes stream without a bubble.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Send a full frame; a bad sum is off by a random nonzero amount.
  task automatic send_frame(input logic [WordW-1:0] dist_cm, input logic [WordW-1:0] strength,
                            input logic [WordW-1:0] temp_raw, input bit bad_sum);
    logic [8:0][ByteW-1:0] fb;
    logic [ByteW-1:0]      sum;
    fb  = {8'h00, temp_raw, strength, dist_cm, HEADER_BYTE, HEADER_BYTE};
    sum = '0;
    for (int i = 0; i < 8; i++)
      sum = sum + fb[i];
    fb[8] = bad_sum ? sum + ByteW'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < 9; i++)
      send_byte(fb[i]);
  endtask

  // Drop valid and wait until every predicted frame has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  // Write the distance limit with the decoder idle.
  task automatic write_limit(input logic [DistW-1:0] lim);
    drain_results();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_mm     = lim;
  endtask

  // Distance in cm a few counts around the current limit.
  function automatic logic [WordW-1:0] near_limit_cm();
    int cm;
    cm = int'(limit_mm / 10) + int'($urandom_range(0, 4)) - 2;
    if (cm < 0) cm = 0;
    if (cm > 65535) cm = 65535;
    return WordW'(cm);
  endfunction

  // Field extremes, a broken second header and a bad sum on an over-range frame,
  // all at the reset limit.
  task automatic test_field_extremes();
    send_byte(8'hFF);                          // noise while hunting
    send_byte(HEADER_BYTE);
    send_byte(8'h00);                          // broken second header
    send_frame(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    drain_results();
  endtask

  // Step the limit through its extremes and probe each boundary.
  task automatic test_limit_sweep();
    logic [DistW-1:0] lims [6];
    lims[0] = '0;        // every good frame flagged
    lims[1] = 20'd1;
    lims[2] = 20'd655350;
    lims[3] = 20'd655349;
    lims[4] = LIMIT_RESET;
    lims[5] = DistW'($urandom_range(0, 655350));
    for (int i = 0; i < 6; i++) begin
      write_limit(lims[i]);
      for (int k = 0; k < 3; k++)
        send_frame(near_limit_cm(), WordW'($urandom), WordW'($urandom), 1'b0);
    end
    drain_results();
  endtask

  // Hold the receiver off while frames stream in back to back, so the result
  // register fills and the input stalls on a checksum byte.
  task automatic test_result_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++)
      send_frame(WordW'($urandom), WordW'($urandom), WordW'($urandom), k == 3);
    drain_results();
    idle_on = 1'b1;
  endtask

  // Pause the sender mid-frame until all results are out, then resume.
  task automatic test_sender_pause();
    send_frame(16'd42, 16'd7, 16'd2048, 1'b0);
    drain_results();
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    send_byte(8'h10);
    send_byte(8'h00);
    drain_results();
    for (int k = 0; k < 5; k++)
      send_byte(k == 4 ? 8'hC2 : 8'h00);       // 0x59+0x59+0x10 = 0xC2
    drain_results();
  endtask

  // Random stream: mostly well-formed frames with random content, the rest
  // noise, broken headers and cut-off frames. Retune limit and idling per segment.
  task automatic test_random_stream();
    int framed;
    int seg_bytes;
    int n;
    logic [WordW-1:0] cm;
    logic [ByteW-1:0] b;
    framed = 0;
    for (int seg = 0; framed < 1200; seg++) begin
      case (seg % 5)
        0:       write_limit(DistW'($urandom_range(0, 655350)));
        1:       write_limit('0);
        2:       write_limit(20'd655350);
        default: write_limit(DistW'($urandom_range(1000, 200000)));
      endcase
      idle_on  = (seg % 4) != 3;                 // one segment in four runs flat out
      stall_on = (seg % 4) != 3;
      seg_bytes = 0;
      while (seg_bytes < 290 && framed + seg_bytes < 1200) begin
        case ($urandom_range(0, 9))
          0: begin
            // Noise, heavy on the header value, so it can open frames of its own.
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
              b = ($urandom_range(0, 3) == 0) ? HEADER_BYTE : ByteW'($urandom);
              send_byte(b);
            end
            seg_bytes += n;
          end
          1: begin
            b = ByteW'($urandom);
            if (b == HEADER_BYTE) b = 8'h5A;
            send_byte(HEADER_BYTE);
            send_byte(b);
            seg_bytes += 2;
          end
          2: begin
            // Cut-off frame: the next bytes get taken as its payload.
            n = $urandom_range(0, 5);
            send_byte(HEADER_BYTE);
            send_byte(HEADER_BYTE);
            for (int k = 0; k < n; k++)
              send_byte(ByteW'($urandom));
            seg_bytes += 2 + n;
          end
          default: begin
            case ($urandom_range(0, 2))
              0:       cm = near_limit_cm();
              1:       cm = WordW'($urandom);
              default: cm = WordW'($urandom_range(0, 255));
            endcase
            send_frame(cm, WordW'($urandom), WordW'($urandom), $urandom_range(0, 5) == 0);
            seg_bytes += 9;
            if ($urandom_range(0, 19) == 0)
              drain_results();
          end
        endcase
      end
      framed += seg_bytes;
    end
    drain_results();
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_limit_sweep();
    test_result_backpressure();
    test_sender_pause();
    test_random_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frames_due.size() == 0)
      $display("lidar_frame_decoder_unit_test: done, clean");
    else
      $display("lidar_frame_decoder_unit_test: done, errors");
    $finish;
  end

endmodule
